// File: rtl/etg_pkg.sv
`default_nettype none
package etg_pkg;

    localparam int TIME_BITS_DEF     = 24;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int ELASTIC_DEPTH_DEF = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int VALUE_W    = 32;
    localparam int DELTA_W    = 16;
    localparam int USER_OUT_W = 2;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint LN2_Q30 = 64'sd744261118;
    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint Q16_ONE = 64'sd65536;
    localparam longint ELASTIC_MAX = 64'sd131071;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [2:0] {
        CFG_FROM     = 3'd0,
        CFG_TO       = 3'd1,
        CFG_DURATION = 3'd2,
        CFG_DELAY    = 3'd3,
        CFG_CURVE    = 3'd4,
        CFG_LOOP     = 3'd5,
        CFG_PINGPONG = 3'd6,
        CFG_CLAMP    = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        CURVE_LINEAR     = 4'd0,
        CURVE_INQUAD     = 4'd1,
        CURVE_OUTQUAD    = 4'd2,
        CURVE_INOUTQUAD  = 4'd3,
        CURVE_INCUBIC    = 4'd4,
        CURVE_OUTCUBIC   = 4'd5,
        CURVE_INOUTCUBIC = 4'd6,
        CURVE_OUTBOUNCE  = 4'd7,
        CURVE_OUTELASTIC = 4'd8
    } curve_t;

    localparam logic [1:0] CLAMP_NONE   = 2'd0;
    localparam logic [1:0] CLAMP_UNIT   = 2'd1;
    localparam logic [1:0] CLAMP_NONNEG = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_TSEL,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_EASE,
        ST_INTERP,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_DELAY,
        OP_ADVANCE,
        OP_PREP,
        OP_DIV,
        OP_TSEL,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_EASE,
        OP_INTERP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic delay_hold;
        logic out_busy;
    } dp_status_t;

    // elaboration-time helpers for the elastic curve table
    function automatic longint exp_neg_q30(input longint y);
        longint sum;
        longint term;
        sum  = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * y) >>> 30) / 64'(k);
            if ((k & 1) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum < 0) ? 64'sd0 : sum;
    endfunction

    function automatic longint unsigned sin_q30(input longint unsigned th);
        longint unsigned th2;
        longint unsigned term;
        longint sum;
        th2  = (th * th) >> 30;
        sum  = longint'(th);
        term = th;
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return longint'(sum);
    endfunction

    function automatic logic [16:0] elastic_finish(input longint a,
                                                   input longint unsigned sv,
                                                   input longint q);
        longint unsigned mag;
        longint v;
        mag = (longint'(unsigned'(a)) * sv + (64'd1 << 43)) >> 44;
        if (q >= 2)
            v = Q16_ONE - longint'(mag);
        else
            v = Q16_ONE + longint'(mag);
        if (v < 0)
            v = 0;
        if (v > ELASTIC_MAX)
            v = ELASTIC_MAX;
        return v[16:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/etg_ctrl.sv
`default_nettype none
module etg_ctrl #(
    parameter int FRAC_BITS = etg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tuser,   // mode
    output logic                       s_tready,
    input  wire etg_pkg::dp_status_t   status,
    output etg_pkg::dp_cmd_t           cmd
);
    import etg_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    priority if (s_tuser == MODE_START)
                        cmd.op = OP_START;
                    else if (!status.active)
                        cmd.op = OP_NONE;
                    else if (status.delay_hold)
                        cmd.op = OP_DELAY;
                    else
                    begin
                        cmd.op     = OP_ADVANCE;
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.op     = OP_PREP;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                    state_next = ST_TSEL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_TSEL:
            begin
                cmd.op     = OP_TSEL;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.op     = OP_M1;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.op     = OP_M2;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cmd.op     = OP_M3;
                state_next = ST_EASE;
            end
            ST_EASE:
            begin
                cmd.op     = OP_EASE;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.op     = OP_INTERP;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold here while the previous result is still waiting
                if (!status.out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_prep_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PREP |=> state_reg == ST_DIV)
        else $error("prep not followed by divide");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(FRAC_BITS - 1)) |=> state_reg == ST_TSEL)
        else $error("divide did not end after all quotient bits");

    a_m1_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_M1 |-> $past(state_reg == ST_TSEL))
        else $error("multiply sequence entered out of order");

endmodule
`default_nettype wire

// File: rtl/etg_datapath.sv
`default_nettype none
module etg_datapath #(
    parameter int TIME_BITS     = etg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS     = etg_pkg::FRAC_BITS_DEF,
    parameter int ELASTIC_DEPTH = etg_pkg::ELASTIC_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [etg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [etg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [etg_pkg::DELTA_W-1:0]       delta,
    input  wire etg_pkg::dp_cmd_t                  cmd,
    output etg_pkg::dp_status_t                    status,
    input  wire logic                              m_tready,
    output logic                                   m_tvalid,
    output logic [etg_pkg::VALUE_W-1:0]            m_tdata,
    output logic                                   m_tlast,
    output logic [etg_pkg::USER_OUT_W-1:0]         m_tuser
);
    import etg_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int DW    = (TIME_BITS < 24) ? TIME_BITS : 24;
    localparam int EW    = TIME_BITS + 1;
    localparam int EV    = F + 2;
    localparam int AW    = 34;
    localparam int BW    = ((F + 3) > 18) ? (F + 3) : 18;
    localparam int PW    = AW + BW;
    localparam int IDX_W = $clog2(ELASTIC_DEPTH);
    localparam int ROM_N = 2 ** IDX_W;
    localparam int CMPW  = (DW > DELTA_W) ? DW : DELTA_W;
    localparam int SW    = ((EW > DELTA_W) ? EW : DELTA_W) + 1;
    localparam int BWW   = F + 7;
    localparam int UP    = (F >= 16) ? (F - 16) : 0;
    localparam int DN    = (F < 16) ? (16 - F) : 0;

    localparam logic [F:0]    ONE_T  = (F + 1)'(1) << F;
    localparam logic [F:0]    HALF_T = ONE_T >> 1;
    localparam logic [EW-1:0] EMAX   = {EW{1'b1}};
    localparam logic signed [PW:0]   HALF_P = (PW + 1)'(1) <<< (F - 1);
    localparam logic signed [PW+1:0] VMAX   = (PW + 2)'(2147483647);
    localparam logic signed [PW+1:0] VMIN   = -(PW + 2)'(2147483647) - 1;

    // elastic curve constants
    logic [16:0] rom [ROM_N];
    for (genvar gi = 0; gi < ROM_N; gi++)
    begin : g_rom
        localparam longint S   = 10 * gi;
        localparam longint N   = S / ELASTIC_DEPTH;
        localparam longint R   = S % ELASTIC_DEPTH;
        localparam longint Y   = (R * LN2_Q30) / ELASTIC_DEPTH;
        localparam longint A   = exp_neg_q30(Y) >>> N;
        localparam longint PN  = (40 * gi + 9 * ELASTIC_DEPTH) % (12 * ELASTIC_DEPTH);
        localparam longint QD  = PN / (3 * ELASTIC_DEPTH);
        localparam longint M0  = PN % (3 * ELASTIC_DEPTH);
        localparam longint M   = ((QD % 2) == 1) ? (3 * ELASTIC_DEPTH - M0) : M0;
        localparam longint TH  = (M * PI_Q30) / (6 * ELASTIC_DEPTH);
        localparam logic [16:0] V = (gi == 0 || gi >= ELASTIC_DEPTH) ? 17'd0
                                   : elastic_finish(A, sin_q30(TH), QD);
        assign rom[gi] = V;
    end

    // configuration
    logic signed [31:0] from_reg, to_reg;
    logic [DW-1:0]      dur_reg, dly_reg;
    logic [3:0]         curve_reg;
    logic               loop_reg, pp_reg;
    logic [1:0]         clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_reg  <= '0;
            to_reg    <= '0;
            dur_reg   <= '0;
            dly_reg   <= '0;
            curve_reg <= '0;
            loop_reg  <= 1'b0;
            pp_reg    <= 1'b0;
            clamp_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_FROM:     from_reg  <= cfg_wdata;
                CFG_TO:       to_reg    <= cfg_wdata;
                CFG_DURATION: dur_reg   <= cfg_wdata[DW-1:0];
                CFG_DELAY:    dly_reg   <= cfg_wdata[DW-1:0];
                CFG_CURVE:    curve_reg <= cfg_wdata[3:0];
                CFG_LOOP:     loop_reg  <= cfg_wdata[0];
                CFG_PINGPONG: pp_reg    <= cfg_wdata[0];
                CFG_CLAMP:    clamp_reg <= cfg_wdata[1:0];
            endcase
        end
    end

    // tween state and work registers
    logic [EW-1:0]        elapsed_reg;
    logic [DW-1:0]        delay_reg;
    logic                 active_reg, rev_reg, fin_reg;
    logic [DW-1:0]        rem_reg;
    logic [F-1:0]         q_reg;
    logic [F:0]           tm_reg;
    logic signed [PW-1:0] mul_reg, p1_reg, p2_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [F-1:0]         fr_reg;
    logic [EV-1:0]        e_reg;
    logic                 out_valid_reg, last_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [1:0]           user_reg;

    logic [CMPW-1:0] dt_x, dl_x;
    logic [SW-1:0]   sum_el;
    logic [DW:0]     rem2;
    logic [F:0]      t_full, u_t, s_sel;
    logic            lt_half;
    curve_t          curve;

    assign dt_x   = CMPW'(delta);
    assign dl_x   = CMPW'(delay_reg);
    assign sum_el = SW'(elapsed_reg) + SW'(delta);
    assign rem2   = {rem_reg, 1'b0};
    assign t_full = fin_reg ? ONE_T : {1'b0, q_reg};
    assign u_t    = ONE_T - tm_reg;
    assign lt_half = tm_reg < HALF_T;
    assign curve  = curve_t'(curve_reg);

    always_comb
    begin
        unique case (curve)
            CURVE_OUTCUBIC:   s_sel = u_t;
            CURVE_INOUTQUAD,
            CURVE_INOUTCUBIC: s_sel = lt_half ? tm_reg : u_t;
            default:          s_sel = tm_reg;
        endcase
    end

    // bounce segments on 11t
    logic [BWW-1:0] one_w, t11, t22, wv;
    logic [F+1:0]   w_abs;
    logic [1:0]     bseg;
    assign one_w = BWW'(ONE_T);
    assign t11   = BWW'(tm_reg) * BWW'(11);
    assign t22   = t11 << 1;

    always_comb
    begin
        priority if (t11 < (one_w << 2))
        begin
            bseg = 2'd0;
            wv   = t11;
        end
        else if (t11 < (one_w << 3))
        begin
            bseg = 2'd1;
            wv   = t11 - one_w * BWW'(6);
        end
        else if (t11 < one_w * BWW'(10))
        begin
            bseg = 2'd2;
            wv   = t11 - one_w * BWW'(9);
        end
        else
        begin
            bseg = 2'd3;
            wv   = t22 - one_w * BWW'(21);
        end
    end
    always_comb
    begin
        logic [BWW-1:0] wn;
        wn    = -wv;
        w_abs = wv[BWW-1] ? wn[F+1:0] : wv[F+1:0];
    end

    // shared multiplier operands
    logic signed [AW-1:0] a_op;
    logic signed [BW-1:0] b_op;
    logic [IDX_W-1:0]     idx_cur;
    logic [F-1:0]         fr_cur;
    logic [IDX_W:0]       nidx;
    logic [16:0]          rom_b;

    assign idx_cur = mul_reg[F +: IDX_W];
    assign fr_cur  = mul_reg[F-1:0];
    assign nidx    = {1'b0, idx_reg} + 1'b1;
    assign rom_b   = (nidx < (IDX_W + 1)'(ELASTIC_DEPTH)) ? rom[nidx[IDX_W-1:0]] : 17'h10000;

    always_comb
    begin
        logic signed [PW-1:0] p_sh;
        p_sh = mul_reg >>> F;
        a_op = '0;
        b_op = '0;
        unique case (cmd.op)
            OP_M1:
            begin
                unique case (curve)
                    CURVE_INQUAD, CURVE_INOUTQUAD, CURVE_INCUBIC,
                    CURVE_OUTCUBIC, CURVE_INOUTCUBIC:
                    begin
                        a_op = $signed(AW'(s_sel));
                        b_op = $signed(BW'(s_sel));
                    end
                    CURVE_OUTQUAD:
                    begin
                        a_op = $signed(AW'(tm_reg));
                        b_op = $signed(BW'((F + 2)'(ONE_T) * (F + 2)'(2) - (F + 2)'(tm_reg)));
                    end
                    CURVE_OUTBOUNCE:
                    begin
                        a_op = $signed(AW'(w_abs));
                        b_op = $signed(BW'(w_abs));
                    end
                    CURVE_OUTELASTIC:
                    begin
                        a_op = $signed(AW'(tm_reg));
                        b_op = $signed(BW'(ELASTIC_DEPTH));
                    end
                    default:
                    begin
                        a_op = '0;
                        b_op = '0;
                    end
                endcase
            end
            OP_M2:
            begin
                unique case (curve)
                    CURVE_INCUBIC, CURVE_OUTCUBIC, CURVE_INOUTCUBIC:
                    begin
                        a_op = $signed(AW'(p_sh[F+1:0]));
                        b_op = $signed(BW'(s_sel));
                    end
                    CURVE_OUTELASTIC:
                    begin
                        a_op = $signed(AW'(rom[idx_cur]));
                        b_op = $signed(BW'(ONE_T - (F + 1)'(fr_cur)));
                    end
                    default:
                    begin
                        a_op = '0;
                        b_op = '0;
                    end
                endcase
            end
            OP_M3:
            begin
                if (curve == CURVE_OUTELASTIC)
                begin
                    a_op = $signed(AW'(rom_b));
                    b_op = $signed(BW'(fr_reg));
                end
            end
            OP_INTERP:
            begin
                a_op = AW'(to_reg) - AW'(from_reg);
                b_op = $signed(BW'(e_reg));
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // eased fraction from the stored products
    logic [EV-1:0] e_next;
    always_comb
    begin
        logic [F+3:0]         q1, q2, bq;
        logic signed [PW-1:0] p1s, p2s, bsh, esum;
        logic [EV+17:0]       e16w;
        logic [F+3:0]         badd;
        p1s  = p1_reg >>> F;
        p2s  = p2_reg >>> F;
        q1   = p1s[F+3:0];
        q2   = p2s[F+3:0];
        bsh  = (bseg == 2'd3) ? (p1_reg >>> (F + 6)) : (p1_reg >>> (F + 4));
        bq   = bsh[F+3:0];
        unique case (bseg)
            2'd0:    badd = '0;
            2'd1:    badd = (F + 4)'(ONE_T >> 2) * (F + 4)'(3);
            2'd2:    badd = (F + 4)'(ONE_T >> 4) * (F + 4)'(15);
            default: badd = (F + 4)'(ONE_T >> 6) * (F + 4)'(63);
        endcase
        esum = p2_reg + mul_reg;
        e16w = (EV + 18)'(esum[F +: 18]);
        e16w = (e16w << UP) >> DN;
        unique case (curve)
            CURVE_INQUAD, CURVE_OUTQUAD: e_next = q1[EV-1:0];
            CURVE_INOUTQUAD:
            begin
                bq     = lt_half ? (q1 << 1) : ((F + 4)'(ONE_T) - (q1 << 1));
                e_next = bq[EV-1:0];
            end
            CURVE_INCUBIC:  e_next = q2[EV-1:0];
            CURVE_OUTCUBIC:
            begin
                bq     = (F + 4)'(ONE_T) - q2;
                e_next = bq[EV-1:0];
            end
            CURVE_INOUTCUBIC:
            begin
                bq     = lt_half ? (q2 << 2) : ((F + 4)'(ONE_T) - (q2 << 2));
                e_next = bq[EV-1:0];
            end
            CURVE_OUTBOUNCE:
            begin
                bq     = bq + badd;
                e_next = bq[EV-1:0];
            end
            CURVE_OUTELASTIC:
            begin
                // endpoints bypass the table
                if (tm_reg == '0 || tm_reg >= ONE_T)
                    e_next = EV'(tm_reg);
                else
                    e_next = e16w[EV-1:0];
            end
            default: e_next = EV'(tm_reg);
        endcase
    end

    // rounding, saturation and clamp of the result
    logic [VALUE_W-1:0] res_value;
    logic               stop_now, rev_after, act_after;
    always_comb
    begin
        logic signed [PW:0]   rnd;
        logic signed [PW+1:0] val;
        logic signed [31:0]   v32;
        rnd = ($signed({mul_reg[PW-1], mul_reg}) + HALF_P) >>> F;
        val = (PW + 2)'(from_reg) + (PW + 2)'(rnd);
        if (stop_now)
            val = (PW + 2)'(to_reg);
        priority if (val > VMAX)
            v32 = 32'sh7fffffff;
        else if (val < VMIN)
            v32 = 32'sh80000000;
        else
            v32 = val[31:0];
        priority if (clamp_reg == CLAMP_UNIT)
        begin
            if (v32 < 0)
                v32 = '0;
            else if (v32 > 32'sd65536)
                v32 = 32'sd65536;
        end
        else if (clamp_reg == CLAMP_NONNEG)
        begin
            if (v32 < 0)
                v32 = '0;
        end
        else
        begin
            v32 = v32;
        end
        res_value = v32;
    end

    assign stop_now  = fin_reg && !pp_reg && !loop_reg;
    assign rev_after = (fin_reg && pp_reg) ? !rev_reg : rev_reg;
    assign act_after = stop_now ? 1'b0 : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= '0;
            delay_reg     <= '0;
            active_reg    <= 1'b0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (cmd.op)
                OP_START:
                begin
                    delay_reg   <= dly_reg;
                    elapsed_reg <= '0;
                    rev_reg     <= 1'b0;
                    active_reg  <= 1'b1;
                end
                OP_DELAY:
                begin
                    delay_reg <= delay_reg - DW'(delta);
                end
                OP_ADVANCE:
                begin
                    delay_reg   <= '0;
                    elapsed_reg <= (sum_el > SW'(EMAX)) ? EMAX : sum_el[EW-1:0];
                end
                OP_RESULT:
                begin
                    rev_reg    <= rev_after;
                    active_reg <= act_after;
                    if (fin_reg && (pp_reg || loop_reg))
                        elapsed_reg <= '0;
                end
                default:
                begin
                    active_reg <= active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_PREP:
            begin
                fin_reg <= (dur_reg == '0) || (elapsed_reg >= EW'(dur_reg));
                rem_reg <= elapsed_reg[DW-1:0];
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                // one restoring quotient bit per cycle
                if (rem2 >= {1'b0, dur_reg})
                begin
                    rem_reg <= rem2[DW-1:0] - dur_reg;
                    q_reg   <= {q_reg[F-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[DW-1:0];
                    q_reg   <= {q_reg[F-2:0], 1'b0};
                end
            end
            OP_TSEL:
            begin
                tm_reg <= rev_reg ? (ONE_T - t_full) : t_full;
            end
            OP_M1:
            begin
                mul_reg <= a_op * b_op;
            end
            OP_M2:
            begin
                p1_reg  <= mul_reg;
                idx_reg <= idx_cur;
                fr_reg  <= fr_cur;
                mul_reg <= a_op * b_op;
            end
            OP_M3:
            begin
                p2_reg  <= mul_reg;
                mul_reg <= a_op * b_op;
            end
            OP_EASE:
            begin
                e_reg <= e_next;
            end
            OP_INTERP:
            begin
                mul_reg <= a_op * b_op;
            end
            OP_RESULT:
            begin
                value_reg <= res_value;
                last_reg  <= fin_reg;
                user_reg  <= {act_after, rev_after};
            end
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    assign status.active     = active_reg;
    assign status.delay_hold = (delay_reg != '0) && (dt_x < dl_x);
    assign status.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_RESULT |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken transfer");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == OP_RESULT))
        else $error("output valid without a result step");

    a_stop_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT && fin_reg && !pp_reg && !loop_reg) |=> !active_reg)
        else $error("final stop left the channel running");

endmodule
`default_nettype wire

// File: rtl/eased_tween_generator.sv
// operation: a tick that advances time runs a restoring divide, one quotient bit per cycle,
//   then four multiplies and a result step that waits while the receiver holds the output
// input: no new tick is taken until the advancing tick's result is stored; start, idle
//   and delay ticks are handled in the idle state and give no result
// reset: asynchronous, active low; clears configuration, tween state and output valid
`default_nettype none
module eased_tween_generator #(
    parameter int TIME_BITS     = etg_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS     = etg_pkg::FRAC_BITS_DEF,
    parameter int ELASTIC_DEPTH = etg_pkg::ELASTIC_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [etg_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [etg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [etg_pkg::DELTA_W-1:0]       s_tdata,   // [15:0] delta_ticks
    input  wire logic                              s_tuser,   // [0] mode
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [etg_pkg::VALUE_W-1:0]            m_tdata,   // [31:0] value
    output logic                                   m_tlast,   // finished
    output logic [etg_pkg::USER_OUT_W-1:0]         m_tuser    // [0] reverse_phase, [1] running
);
    import etg_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    etg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    etg_datapath #(
        .TIME_BITS     (TIME_BITS),
        .FRAC_BITS     (FRAC_BITS),
        .ELASTIC_DEPTH (ELASTIC_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .delta     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

// File: bench/tb_eased_tween_generator.sv
`default_nettype none
module tb_eased_tween_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import etg_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DEPTH = ELASTIC_DEPTH_DEF;
    localparam longint unsigned ONE = 64'd1 << FRAC;
    localparam longint unsigned ELAPSED_SAT = (64'd1 << (TIME_BITS_DEF + 1)) - 1;
    localparam int DRAIN_CYCLES = FRAC + 24;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct {
        logic [31:0] value;
        logic        fin;
        logic        rev;
        logic        run;
    } tween_out_t;

    class tween_tracker;
        logic [31:0] from_r, to_r;
        logic [23:0] dur_r, dly_r;
        logic [3:0]  curve_r;
        logic        loop_r, pp_r;
        logic [1:0]  clamp_r;

        longint unsigned elapsed, delay_left;
        bit active, rev;
        longint unsigned elastic[DEPTH];
        tween_out_t pending_outputs[$];
        int errors;

        function new();
            longint sum, term, y, a, pn, q, m, sv, v;
            longint unsigned th, th2, uterm, mag;
            for (int i = 0; i < DEPTH; i++)
            begin
                if (i == 0)
                begin
                    elastic[i] = 0;
                    continue;
                end
                // 2^(-10x) from the fractional octave, whole octaves as a shift
                y = (longint'((10 * i) % DEPTH) * LN2_Q30) / DEPTH;
                sum = Q30_ONE;
                term = Q30_ONE;
                for (int k = 1; k <= 14; k++)
                begin
                    term = ((term * y) >>> 30) / k;
                    sum = (k % 2 == 1) ? sum - term : sum + term;
                end
                if (sum < 0)
                    sum = 0;
                a = sum >>> ((10 * i) / DEPTH);
                // sine phase folded into the first quadrant
                pn = (40 * i + 9 * DEPTH) % (12 * DEPTH);
                q = pn / (3 * DEPTH);
                m = pn % (3 * DEPTH);
                if (q % 2 == 1)
                    m = 3 * DEPTH - m;
                th = longint'(m * PI_Q30) / (6 * DEPTH);
                th2 = (th * th) >> 30;
                sum = longint'(th);
                uterm = th;
                for (int k = 1; k <= 9; k++)
                begin
                    uterm = ((uterm * th2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    sum = (k % 2 == 1) ? sum - longint'(uterm) : sum + longint'(uterm);
                end
                if (sum < 0)
                    sum = 0;
                if (sum > Q30_ONE)
                    sum = Q30_ONE;
                sv = sum;
                mag = (longint'(a) * longint'(sv) + (64'd1 << 43)) >> 44;
                v = (q >= 2) ? Q16_ONE - longint'(mag) : Q16_ONE + longint'(mag);
                if (v < 0)
                    v = 0;
                if (v > ELASTIC_MAX)
                    v = ELASTIC_MAX;
                elastic[i] = v;
            end
        endfunction

        function void clear();
            from_r = 0; to_r = 0; dur_r = 0; dly_r = 0;
            curve_r = 0; loop_r = 0; pp_r = 0; clamp_r = 0;
            elapsed = 0; delay_left = 0; active = 0; rev = 0;
        endfunction

        function void apply_config(cfg_reg_t idx, logic [31:0] d);
            case (idx)
                CFG_FROM:     from_r = d;
                CFG_TO:       to_r = d;
                CFG_DURATION: dur_r = d[23:0];
                CFG_DELAY:    dly_r = d[23:0];
                CFG_CURVE:    curve_r = d[3:0];
                CFG_LOOP:     loop_r = d[0];
                CFG_PINGPONG: pp_r = d[0];
                CFG_CLAMP:    clamp_r = d[1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned fmul(longint unsigned x, longint unsigned z);
            return (x * z) >> FRAC;
        endfunction

        function longint unsigned bounce_sq(longint w, int shift_extra);
            return longint'(w * w) >> (FRAC + shift_extra);
        endfunction

        function longint unsigned eased(longint unsigned t);
            longint unsigned u, pos, idx, fr, ea, eb;
            longint ti, one;
            u = ONE - t;
            ti = longint'(t);
            one = longint'(ONE);
            case (curve_r)
                CURVE_INQUAD:    return fmul(t, t);
                CURVE_OUTQUAD:   return fmul(t, 2 * ONE - t);
                CURVE_INOUTQUAD: return (t < ONE / 2) ? 2 * fmul(t, t) : ONE - 2 * fmul(u, u);
                CURVE_INCUBIC:   return fmul(fmul(t, t), t);
                CURVE_OUTCUBIC:  return ONE - fmul(fmul(u, u), u);
                CURVE_INOUTCUBIC:
                    return (t < ONE / 2) ? 4 * fmul(fmul(t, t), t)
                                         : ONE - 4 * fmul(fmul(u, u), u);
                CURVE_OUTBOUNCE:
                begin
                    if (11 * ti < 4 * one)
                        return bounce_sq(11 * ti, 4);
                    if (11 * ti < 8 * one)
                        return bounce_sq(11 * ti - 6 * one, 4) + 3 * (ONE >> 2);
                    if (11 * ti < 10 * one)
                        return bounce_sq(11 * ti - 9 * one, 4) + 15 * (ONE >> 4);
                    return bounce_sq(22 * ti - 21 * one, 6) + 63 * (ONE >> 6);
                end
                CURVE_OUTELASTIC:
                begin
                    if (t == 0 || t >= ONE)
                        return t;
                    pos = t * DEPTH;
                    idx = pos >> FRAC;
                    fr = pos & (ONE - 1);
                    ea = elastic[idx];
                    eb = (idx + 1 < DEPTH) ? elastic[idx + 1] : 65536;
                    return (ea * (ONE - fr) + eb * fr) >> FRAC;
                end
                default: return t;
            endcase
        endfunction

        function void note_transfer(logic md, logic [15:0] dt);
            longint unsigned t, e;
            longint fv, tv, val;
            bit fin;
            tween_out_t o;
            if (md == MODE_START)
            begin
                delay_left = dly_r;
                elapsed = 0;
                rev = 0;
                active = 1;
                return;
            end
            if (!active)
                return;
            if (delay_left > 0)
            begin
                if (dt < delay_left)
                begin
                    delay_left -= dt;
                    return;
                end
                delay_left = 0;
            end
            elapsed += dt;
            if (elapsed > ELAPSED_SAT)
                elapsed = ELAPSED_SAT;
            fin = (dur_r == 0 || elapsed >= dur_r);
            t = fin ? ONE : (elapsed << FRAC) / dur_r;
            e = eased(rev ? ONE - t : t);
            fv = longint'(signed'(from_r));
            tv = longint'(signed'(to_r));
            val = fv + (((tv - fv) * longint'(e) + longint'(ONE / 2)) >>> FRAC);
            if (fin)
            begin
                if (pp_r)
                begin
                    rev = !rev;
                    elapsed = 0;
                end
                else if (loop_r)
                    elapsed = 0;
                else
                begin
                    active = 0;
                    val = tv;
                end
            end
            if (val > 64'sd2147483647)
                val = 64'sd2147483647;
            if (val < -64'sd2147483648)
                val = -64'sd2147483648;
            if (clamp_r == CLAMP_UNIT)
            begin
                if (val < 0)
                    val = 0;
                if (val > Q16_ONE)
                    val = Q16_ONE;
            end
            else if (clamp_r == CLAMP_NONNEG && val < 0)
                val = 0;
            o.value = val[31:0];
            o.fin = fin;
            o.rev = rev;
            o.run = active;
            pending_outputs = {pending_outputs, o};
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        endtask

        task check_output(logic [31:0] value, logic fin, logic [1:0] user);
            tween_out_t o;
            if (pending_outputs.size() == 0)
            begin
                report_mismatch("unexpected transfer", value, 0);
                return;
            end
            o = pending_outputs.pop_front();
            if (value !== o.value)
                report_mismatch("value", value, o.value);
            if (fin !== o.fin)
                report_mismatch("finished", 32'(fin), 32'(o.fin));
            if (user[0] !== o.rev)
                report_mismatch("reverse_phase", 32'(user[0]), 32'(o.rev));
            if (user[1] !== o.run)
                report_mismatch("running", 32'(user[1]), 32'(o.run));
        endtask
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_addr = 0;
    logic [31:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    tween_tracker sb = new();
    int items_sent = 0;
    int burst_left = 0;
    int stall_style = 0;
    int stall_count = 0;

    eased_tween_generator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    // receiver: checks each taken transfer; the stall style is redrawn periodically
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata, m_tlast, m_tuser);
        stall_count++;
        if (stall_count % 300 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_count % 5 == 0);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= d;
        @(posedge clk);
        sb.apply_config(idx, d);
    endtask

    // narrow registers get junk in their unused upper bits
    task automatic set_config(logic [31:0] from_v, logic [31:0] to_v, logic [23:0] dur,
                              logic [23:0] dly, logic [3:0] curve, logic lp, logic pp,
                              logic [1:0] clamp);
        write_reg(CFG_FROM, from_v);
        write_reg(CFG_TO, to_v);
        write_reg(CFG_DURATION, {8'($urandom_range(0, 255)), dur});
        write_reg(CFG_DELAY, {8'($urandom_range(0, 255)), dly});
        write_reg(CFG_CURVE, {28'($urandom), curve});
        write_reg(CFG_LOOP, {31'($urandom), lp});
        write_reg(CFG_PINGPONG, {31'($urandom), pp});
        write_reg(CFG_CLAMP, {30'($urandom), clamp});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(logic md, logic [15:0] dt);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= dt;
        s_tuser <= md;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_transfer(md, dt);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 65536);
            3: return $urandom_range(0, 16) << 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase();
        logic [23:0] dur, dly;
        int ticks, span;
        logic [15:0] dt;
        case ($urandom_range(0, 15))
            0: dur = 0;
            1: dur = 24'hFF_FFFF;
            2: dur = 24'($urandom);
            default: dur = 24'($urandom_range(1, 60));
        endcase
        case ($urandom_range(0, 11))
            0: dly = 24'hFF_FFFF;
            1, 2, 3, 4, 5: dly = 0;
            default: dly = 24'($urandom_range(1, 40));
        endcase
        set_config(pick_value(), pick_value(), dur, dly, 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)));
        span = (dur < 60 && dur > 0) ? dur / 3 + 2 : 8;
        ticks = $urandom_range(4, 40);
        if ($urandom_range(0, 9) != 0)
            send_item(MODE_START, 16'($urandom));
        for (int i = 0; i < ticks; i++)
        begin
            case ($urandom_range(0, 19))
                0: dt = 16'hFFFF;
                1: dt = 16'($urandom);
                2: dt = 0;
                default: dt = 16'($urandom_range(0, span));
            endcase
            // occasional restart in the middle of a run
            send_item(($urandom_range(0, 29) == 0) ? MODE_START : MODE_TICK, dt);
        end
        drain();
    endtask

    initial
    begin
        sb.clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks give nothing, then a start with reset settings finishes at once
        send_item(MODE_TICK, 16'hFFFF);
        send_item(MODE_TICK, 16'h0000);
        send_item(MODE_START, 16'h0000);
        send_item(MODE_TICK, 16'h0001);
        drain();
        for (int c = 0; c <= 9; c++)
        begin
            set_config((c % 2 == 1) ? 32'h8000_0000 : 32'h0000_0000,
                       (c % 2 == 1) ? 32'h7FFF_FFFF : 32'h0001_0000,
                       (c == 9) ? 24'hFF_FFFF : 24'd4, 24'd2,
                       (c == 9) ? 4'd15 : 4'(c), c % 3 == 0, c % 4 == 2, 2'(c % 4));
            send_item(MODE_START, 16'hFFFF);
            send_item(MODE_TICK, (c == 9) ? 16'hFFFF : 16'd3);
            drain();
        end

        while (items_sent < RANDOM_ITEMS)
            random_phase();

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
